// ===== hdl/segment_plane_display_buffer_assert.svh =====
// Assertion macros for the segment plane display buffer.
`ifndef SEGMENT_PLANE_DISPLAY_BUFFER_ASSERT_SVH
`define SEGMENT_PLANE_DISPLAY_BUFFER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/spdb_pkg.sv =====
package spdb_pkg;

  localparam int NUM_PLANES     = 8;
  localparam int NUM_DIGITS_DEF = 6;
  localparam int PLANE_W        = $clog2(NUM_PLANES);
  localparam int BANK_ADDR_W    = PLANE_W + 1;
  localparam int MODE_W         = 3;
  localparam int DIGIT_W        = 4;
  localparam int VALUE_W        = 8;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 8;
  localparam int TICK_W         = 3;

  typedef logic [DATA_W-1:0] plane_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW    = 3'd0,
    MODE_BCD    = 3'd1,
    MODE_PAIR   = 3'd2,
    MODE_LETTER = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_SWAP   = 3'd5,
    MODE_SEND   = 3'd6,
    MODE_TICKER = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLYPH,
    ST_CLEAR,
    ST_SEND
  } state_t;

  function automatic logic [2:0] wiring_bit(input logic [2:0] idx);
    logic [2:0] b;
    unique case (idx)
      3'd0:    b = 3'd0;
      3'd1:    b = 3'd4;
      3'd2:    b = 3'd3;
      3'd3:    b = 3'd1;
      3'd4:    b = 3'd5;
      3'd5:    b = 3'd2;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic plane_t bcd_glyph(input logic [3:0] code);
    plane_t g;
    unique case (code)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h40;
      4'hB: g = 8'h79;
      4'hC: g = 8'h76;
      4'hD: g = 8'h38;
      4'hE: g = 8'h73;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic plane_t letter_glyph(input logic [7:0] idx);
    plane_t g;
    unique case (idx)
      8'd0:  g = 8'h5F;
      8'd1:  g = 8'h7C;
      8'd2:  g = 8'h58;
      8'd3:  g = 8'h5E;
      8'd4:  g = 8'h7B;
      8'd5:  g = 8'h71;
      8'd6:  g = 8'h6F;
      8'd7:  g = 8'h74;
      8'd8:  g = 8'h10;
      8'd9:  g = 8'h0C;
      8'd10: g = 8'h75;
      8'd11: g = 8'h30;
      8'd12: g = 8'h14;
      8'd13: g = 8'h54;
      8'd14: g = 8'h5C;
      8'd15: g = 8'h73;
      8'd16: g = 8'h67;
      8'd17: g = 8'h50;
      8'd18: g = 8'h6D;
      8'd19: g = 8'h78;
      8'd20: g = 8'h1C;
      8'd21: g = 8'h1C;
      8'd22: g = 8'h14;
      8'd23: g = 8'h76;
      8'd24: g = 8'h6E;
      8'd25: g = 8'h5B;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/segment_plane_display_buffer.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   mode, digit, value
// out_      output     out_valid/out_stall reg_address, reg_data, last
//
// Glyph writes hold in_stall after the transfer while they rewrite every plane, one plane per cycle through
// the shared read-modify-write unit (both digits in turn for a decimal pair with both in range,
// no stall when the digit is out of range); clear holds it too, swap and ticker do not.
// Send holds it while it reads out every plane, and also while out_stall blocks the output register.
// rst_n clears the planes, bank select, ticker and sequencer.
// in_stall is high while a multi-cycle item is in flight.
`include "segment_plane_display_buffer_assert.svh"

module segment_plane_display_buffer #(
  parameter int NUM_DIGITS = spdb_pkg::NUM_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spdb_pkg::MODE_W-1:0]  in_mode,
  input  logic [spdb_pkg::DIGIT_W-1:0] in_digit,
  input  logic [spdb_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spdb_pkg::ADDR_W-1:0]  out_reg_address,
  output logic [spdb_pkg::DATA_W-1:0]  out_reg_data,
  output logic                         out_last
);
  import spdb_pkg::*;

  localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);

  state_t state_r, state_nxt;

  plane_t                 plane_r [2*NUM_PLANES];
  logic                   bank_r;
  logic [TICK_W-1:0]      tick_r;
  logic [PLANE_W-1:0]     p_r;
  plane_t                 segs_r, mask_r, segs2_r, mask2_r;
  logic                   pair_r;

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  plane_t                 out_data_r;
  logic                   out_last_r;

  logic                   accept, slot_free, load_out, wr_en, p_adv;
  logic [BANK_ADDR_W-1:0] wr_addr, rd_addr;
  plane_t                 wr_data, rd_data;
  mode_t                  mode;

  logic [15:0]            prod;
  logic [4:0]             tens;
  logic [7:0]             ones_full;
  logic [4:0]             digit2;
  logic                   v1, v2;
  plane_t                 m1, m2, g1, g2;
  logic [3:0]             tick_inc;

  assign mode      = mode_t'(in_mode);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_data   = plane_r[rd_addr];

  // value / 10 by reciprocal, exact for 8-bit values
  assign prod      = 16'(in_value) * 16'd205;
  assign tens      = prod[15:11];
  assign ones_full = in_value - (8'({tens, 3'b000}) + 8'({tens, 1'b0}));

  assign digit2 = 5'(in_digit) + 5'd1;
  assign v1     = (in_digit >= 4'd1) && (in_digit <= 4'd8);
  assign v2     = (digit2 >= 5'd1) && (digit2 <= 5'd8);
  assign m1     = plane_t'(1) << wiring_bit(3'(in_digit - 4'd1));
  assign m2     = plane_t'(1) << wiring_bit(in_digit[2:0]);

  always_comb begin
    g1 = '0;
    g2 = '0;
    unique case (mode)
      MODE_RAW:    g1 = in_value;
      MODE_BCD:    g1 = bcd_glyph(in_value[3:0]) | {in_value[7], 7'b0};
      MODE_PAIR: begin
        g1 = bcd_glyph(tens[3:0]);
        g2 = bcd_glyph(ones_full[3:0]);
      end
      MODE_LETTER: g1 = letter_glyph(in_value);
      default:     g1 = '0;
    endcase
  end

  assign tick_inc = 4'(tick_r) + 4'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_RAW, MODE_BCD, MODE_LETTER: state_nxt = v1 ? ST_GLYPH : ST_IDLE;
            MODE_PAIR:  state_nxt = (v1 || v2) ? ST_GLYPH : ST_IDLE;
            MODE_CLEAR: state_nxt = ST_CLEAR;
            MODE_SEND:  state_nxt = ST_SEND;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_GLYPH: if (p_r == LAST_PLANE && !pair_r) state_nxt = ST_IDLE;
      ST_CLEAR: if (p_r == LAST_PLANE) state_nxt = ST_IDLE;
      ST_SEND:  if (slot_free && p_r == LAST_PLANE) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    wr_addr  = {bank_r, p_r};
    wr_data  = '0;
    rd_addr  = {bank_r, p_r};
    load_out = 1'b0;
    p_adv    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && mode == MODE_TICKER) begin
          wr_en   = 1'b1;
          wr_addr = {bank_r, LAST_PLANE};
          wr_data = plane_t'(1) << wiring_bit(tick_r);
        end
      end
      ST_GLYPH: begin
        wr_en   = 1'b1;
        wr_data = segs_r[p_r] ? (rd_data | mask_r) : (rd_data & ~mask_r);
        p_adv   = 1'b1;
      end
      ST_CLEAR: begin
        wr_en = 1'b1;
        p_adv = 1'b1;
      end
      ST_SEND: begin
        rd_addr  = {~bank_r, p_r};
        load_out = slot_free;
        p_adv    = slot_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      tick_r      <= '0;
      p_r         <= '0;
      pair_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2*NUM_PLANES; i++) plane_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) plane_r[wr_addr] <= wr_data;
      if (p_adv) p_r <= p_r + PLANE_W'(1);
      if (accept) begin
        unique case (mode)
          MODE_SWAP:   bank_r <= ~bank_r;
          MODE_TICKER: tick_r <= (tick_inc >= 4'(NUM_DIGITS)) ? '0 : tick_inc[TICK_W-1:0];
          MODE_PAIR: begin
            segs_r  <= v1 ? g1 : g2;
            mask_r  <= v1 ? m1 : m2;
            segs2_r <= g2;
            mask2_r <= m2;
            pair_r  <= v1 && v2;
          end
          default: begin
            segs_r <= g1;
            mask_r <= m1;
            pair_r <= 1'b0;
          end
        endcase
      end else if (state_r == ST_GLYPH && p_r == LAST_PLANE && pair_r) begin
        segs_r <= segs2_r;
        mask_r <= mask2_r;
        pair_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_addr_r <= ADDR_W'(p_r) + ADDR_W'(1);
      out_data_r <= rd_data;
      out_last_r <= (p_r == LAST_PLANE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_address = out_addr_r;
  assign out_reg_data    = out_data_r;
  assign out_last        = out_last_r;

  `SPDB_ASSERT_NOW(a_last_addr, out_valid_r && out_last_r,
    out_addr_r == ADDR_W'(NUM_PLANES), "last transfer not on final plane")
  `SPDB_ASSERT_NEXT(a_load_valid, load_out, out_valid_r, "loaded output not valid")
  `SPDB_ASSERT_NOW(a_tick_range, 1'b1, 32'(tick_r) < 32'(NUM_DIGITS), "ticker out of range")
  `SPDB_ASSERT_NOW(a_mask_onehot, state_r == ST_GLYPH, $onehot(mask_r), "digit mask not one-hot")
  `SPDB_ASSERT_NOW(a_busy_stall, state_r != ST_IDLE, in_stall, "input taken while busy")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import spdb_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 154;
  localparam int DIRECTED_ROWS = 26;
  localparam int DRAIN_CYCLES = 24;
  // wiring bit per logical digit index, index 0 in the low bits
  localparam logic [23:0] WIRE_POS = {3'd0, 3'd0, 3'd2, 3'd5, 3'd1, 3'd3, 3'd4, 3'd0};

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic last;
  } reg_write_t;

  typedef struct packed {
    mode_t mode;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] value;
    logic fixed;
    logic [DATA_W-1:0] fixed_data;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [MODE_W-1:0] in_mode;
  logic [DIGIT_W-1:0] in_digit;
  logic [VALUE_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic [ADDR_W-1:0] out_reg_address;
  logic [DATA_W-1:0] out_reg_data;
  logic out_last;

  plane_t shadow_planes [2][NUM_PLANES];
  logic shadow_wbank;
  logic [TICK_W-1:0] shadow_tick;
  reg_write_t pending_writes [$];
  reg_write_t head_write;
  stim_row_t plan [DIRECTED_ROWS];

  int errors;
  int cycles = 0;
  int items_sent;
  int sends_sent;
  int writes_checked;
  bit calm;

  segment_plane_display_buffer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_digit(in_digit),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_reg_address(out_reg_address),
    .out_reg_data(out_reg_data),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("cycle %0d: %s got 0x%0h want 0x%0h", cycles, field, got, want);
  endtask

  function automatic plane_t bcd_segments(input logic [3:0] code);
    case (code)
      4'h0: return 8'h3F;
      4'h1: return 8'h06;
      4'h2: return 8'h5B;
      4'h3: return 8'h4F;
      4'h4: return 8'h66;
      4'h5: return 8'h6D;
      4'h6: return 8'h7D;
      4'h7: return 8'h07;
      4'h8: return 8'h7F;
      4'h9: return 8'h6F;
      4'hA: return 8'h40;
      4'hB: return 8'h79;
      4'hC: return 8'h76;
      4'hD: return 8'h38;
      4'hE: return 8'h73;
      default: return 8'h00;
    endcase
  endfunction

  function automatic plane_t letter_segments(input logic [7:0] idx);
    case (idx)
      8'd0: return 8'h5F;
      8'd1: return 8'h7C;
      8'd2: return 8'h58;
      8'd3: return 8'h5E;
      8'd4: return 8'h7B;
      8'd5: return 8'h71;
      8'd6: return 8'h6F;
      8'd7: return 8'h74;
      8'd8: return 8'h10;
      8'd9: return 8'h0C;
      8'd10: return 8'h75;
      8'd11: return 8'h30;
      8'd12: return 8'h14;
      8'd13: return 8'h54;
      8'd14: return 8'h5C;
      8'd15: return 8'h73;
      8'd16: return 8'h67;
      8'd17: return 8'h50;
      8'd18: return 8'h6D;
      8'd19: return 8'h78;
      8'd20: return 8'h1C;
      8'd21: return 8'h1C;
      8'd22: return 8'h14;
      8'd23: return 8'h76;
      8'd24: return 8'h6E;
      8'd25: return 8'h5B;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void draw_glyph(input int digit, input plane_t segs);
    plane_t mask;
    if (digit < 1 || digit > 8) return;
    mask = 8'd1 << WIRE_POS[(digit - 1) * 3 +: 3];
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (segs[p]) shadow_planes[shadow_wbank][p] |= mask;
      else shadow_planes[shadow_wbank][p] &= ~mask;
    end
  endfunction

  // updates the shadow display state and queues the register writes a send produces
  function automatic void shadow_apply(input mode_t mode, input logic [3:0] digit,
                                       input logic [7:0] value, input logic fixed,
                                       input plane_t fixed_data);
    reg_write_t w;
    int next_pos;
    case (mode)
      MODE_RAW: draw_glyph(int'(digit), value);
      MODE_BCD: draw_glyph(int'(digit), bcd_segments(value[3:0]) | (value & 8'h80));
      MODE_PAIR: begin
        draw_glyph(int'(digit), bcd_segments(4'((value / 8'd10) & 8'h0F)));
        draw_glyph(int'(digit) + 1, bcd_segments(4'(value % 8'd10)));
      end
      MODE_LETTER: draw_glyph(int'(digit), letter_segments(value));
      MODE_CLEAR: begin
        for (int p = 0; p < NUM_PLANES; p++) shadow_planes[shadow_wbank][p] = '0;
      end
      MODE_SWAP: shadow_wbank = ~shadow_wbank;
      MODE_SEND: begin
        for (int p = 0; p < NUM_PLANES; p++) begin
          w.addr = ADDR_W'(p + 1);
          w.data = fixed ? fixed_data : shadow_planes[~shadow_wbank][p];
          w.last = (p == NUM_PLANES - 1);
          pending_writes.push_back(w);
        end
      end
      default: begin
        shadow_planes[shadow_wbank][7] = 8'd1 << WIRE_POS[shadow_tick * 3 +: 3];
        next_pos = int'(shadow_tick) + 1;
        shadow_tick = (next_pos >= NUM_DIGITS_DEF) ? '0 : next_pos[TICK_W-1:0];
      end
    endcase
  endfunction

  task automatic push_item(input mode_t mode, input logic [3:0] digit, input logic [7:0] value,
                           input logic fixed, input plane_t fixed_data);
    if (!calm) begin
      while ($urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_digit <= digit;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    shadow_apply(mode, digit, value, fixed, fixed_data);
    items_sent++;
    if (mode == MODE_SEND) sends_sent++;
  endtask

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 16) return MODE_RAW;
    if (r < 32) return MODE_BCD;
    if (r < 46) return MODE_PAIR;
    if (r < 60) return MODE_LETTER;
    if (r < 65) return MODE_CLEAR;
    if (r < 75) return MODE_SWAP;
    if (r < 89) return MODE_SEND;
    return MODE_TICKER;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected register write, address", int'(out_reg_address), 0);
      end else begin
        head_write = pending_writes.pop_front();
        if (out_reg_address !== head_write.addr)
          report_mismatch("reg_address", int'(out_reg_address), int'(head_write.addr));
        if (out_reg_data !== head_write.data)
          report_mismatch("reg_data", int'(out_reg_data), int'(head_write.data));
        if (out_last !== head_write.last)
          report_mismatch("last", int'(out_last), int'(head_write.last));
        writes_checked++;
      end
    end
  end

  initial begin
    logic [3:0] rnd_digit;
    errors = 0;
    items_sent = 0;
    sends_sent = 0;
    writes_checked = 0;
    calm = 1'b0;
    shadow_wbank = 1'b0;
    shadow_tick = '0;
    for (int b = 0; b < 2; b++)
      for (int p = 0; p < NUM_PLANES; p++) shadow_planes[b][p] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_RAW;
    in_digit <= '0;
    in_value <= '0;

    plan = '{
      '{MODE_SEND,   4'd1,  8'd0,   1'b1, 8'h00},
      '{MODE_RAW,    4'd1,  8'hFF,  1'b0, 8'h00},
      '{MODE_RAW,    4'd0,  8'hFF,  1'b0, 8'h00},
      '{MODE_RAW,    4'd15, 8'hAA,  1'b0, 8'h00},
      '{MODE_BCD,    4'd2,  8'h80,  1'b0, 8'h00},
      '{MODE_BCD,    4'd3,  8'h0F,  1'b0, 8'h00},
      '{MODE_BCD,    4'd4,  8'h7A,  1'b0, 8'h00},
      '{MODE_PAIR,   4'd5,  8'd255, 1'b0, 8'h00},
      '{MODE_PAIR,   4'd8,  8'd99,  1'b0, 8'h00},
      '{MODE_LETTER, 4'd6,  8'd25,  1'b0, 8'h00},
      '{MODE_LETTER, 4'd7,  8'd26,  1'b0, 8'h00},
      '{MODE_LETTER, 4'd1,  8'd0,   1'b0, 8'h00},
      '{MODE_SWAP,   4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_SEND,   4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_TICKER, 4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_SWAP,   4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_SEND,   4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_CLEAR,  4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_SWAP,   4'd0,  8'd0,   1'b0, 8'h00},
      '{MODE_SEND,   4'd0,  8'd0,   1'b1, 8'h00}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      push_item(plan[i].mode, plan[i].digit, plan[i].value, plan[i].fixed, plan[i].fixed_data);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 60 && n < 110);
      rnd_digit = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8))
                                               : 4'($urandom_range(0, 15));
      push_item(pick_mode(), rnd_digit, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0)
      report_mismatch("register writes still missing", pending_writes.size(), 0);

    $display("%0d input transfers (%0d directed), %0d sends, %0d register writes checked",
             items_sent, DIRECTED_ROWS, sends_sent, writes_checked);
    $display("all eight modes, digits 0 to 15, bank swaps and ticker wrap exercised");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/spdb_pkg.sv
hdl/segment_plane_display_buffer.sv
dv/tb_top.sv
